### hw/rtl/slts_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, constants and helper functions of the token scanner.
package slts_pkg;

    // Sizing
    localparam int KEYWORD_CHARS    = 8;
    localparam int MAX_TOKEN_LENGTH = 255;
    localparam int WLEN_W           = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int KC_IDX_W         = $clog2(KEYWORD_CHARS);
    localparam int KW_COUNT         = 13;
    localparam int LINE_W           = 16;
    localparam int KIND_W           = 6;
    localparam int LEN_W            = 8;
    localparam int RES_FIFO_DEPTH   = 4;
    localparam int RES_PTR_W        = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W        = $clog2(RES_FIFO_DEPTH + 1);

    // Token kinds
    localparam logic [KIND_W-1:0] K_BEGIN          = 6'd0;
    localparam logic [KIND_W-1:0] K_END            = 6'd1;
    localparam logic [KIND_W-1:0] K_READ           = 6'd2;
    localparam logic [KIND_W-1:0] K_WRITE          = 6'd3;
    localparam logic [KIND_W-1:0] K_IF             = 6'd4;
    localparam logic [KIND_W-1:0] K_THEN           = 6'd5;
    localparam logic [KIND_W-1:0] K_ELSE           = 6'd6;
    localparam logic [KIND_W-1:0] K_ENDIF          = 6'd7;
    localparam logic [KIND_W-1:0] K_WHILE          = 6'd8;
    localparam logic [KIND_W-1:0] K_ENDWHILE       = 6'd9;
    localparam logic [KIND_W-1:0] K_ID             = 6'd10;
    localparam logic [KIND_W-1:0] K_INTLITERAL     = 6'd11;
    localparam logic [KIND_W-1:0] K_FALSEOP        = 6'd12;
    localparam logic [KIND_W-1:0] K_TRUEOP         = 6'd13;
    localparam logic [KIND_W-1:0] K_NULLOP         = 6'd14;
    localparam logic [KIND_W-1:0] K_LPAREN         = 6'd15;
    localparam logic [KIND_W-1:0] K_RPAREN         = 6'd16;
    localparam logic [KIND_W-1:0] K_SEMICOLON      = 6'd17;
    localparam logic [KIND_W-1:0] K_COMMA          = 6'd18;
    localparam logic [KIND_W-1:0] K_ASSIGNOP       = 6'd19;
    localparam logic [KIND_W-1:0] K_PLUSOP         = 6'd20;
    localparam logic [KIND_W-1:0] K_MINUSOP        = 6'd21;
    localparam logic [KIND_W-1:0] K_MULTOP         = 6'd22;
    localparam logic [KIND_W-1:0] K_DIVOP          = 6'd23;
    localparam logic [KIND_W-1:0] K_NOTOP          = 6'd24;
    localparam logic [KIND_W-1:0] K_LESSOP         = 6'd25;
    localparam logic [KIND_W-1:0] K_LESSEQUALOP    = 6'd26;
    localparam logic [KIND_W-1:0] K_GREATEROP      = 6'd27;
    localparam logic [KIND_W-1:0] K_GREATEREQUALOP = 6'd28;
    localparam logic [KIND_W-1:0] K_EQUALOP        = 6'd29;
    localparam logic [KIND_W-1:0] K_NOTEQUALOP     = 6'd30;
    localparam logic [KIND_W-1:0] K_SCANEOF        = 6'd31;
    localparam logic [KIND_W-1:0] K_ERROR          = 6'd32;

    // Characters
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;

    // Keyword table, text right-aligned (first character in the top used byte)
    localparam logic [8*KEYWORD_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        "BEGIN", "END", "READ", "WRITE", "IF", "THEN", "ELSE", "ENDIF",
        "WHILE", "ENDWHILE", "FALSEOP", "TRUEOP", "NULLOP"
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 3, 4, 5, 2, 4, 4, 5, 5, 8, 7, 6, 6};
    localparam logic [KIND_W-1:0] KW_CODE [KW_COUNT] = '{
        K_BEGIN, K_END, K_READ, K_WRITE, K_IF, K_THEN, K_ELSE, K_ENDIF,
        K_WHILE, K_ENDWHILE, K_FALSEOP, K_TRUEOP, K_NULLOP
    };

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_MINUS   = 3'd2,
        MODE_NEGNUM  = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_COLON   = 3'd5,
        MODE_LESS    = 3'd6,
        MODE_GREATER = 3'd7
    } mode_t;

    typedef logic [KEYWORD_CHARS-1:0][6:0] word_store_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
        logic [LEN_W-1:0]  len;
        logic              last;
    } result_t;

    // Up to two results pushed per accepted character
    typedef struct packed {
        logic    en0;
        logic    en1;
        result_t d0;
        result_t d1;
    } res_push_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [WLEN_W-1:0] n);
        if (32'(n) > 32'd255)
            return 8'hFF;
        return LEN_W'(n);
    endfunction

endpackage

### hw/rtl/slts_in_if.sv
`timescale 1ns / 1ps
// Interface: character input channel.
interface slts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, char_code, end_of_text, input ready);
    modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

### hw/rtl/slts_out_if.sv
`timescale 1ns / 1ps
// Interface: token output channel.
interface slts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] line_number;
    logic [7:0]  token_length;
    logic        last_of_run;

    modport source (output valid, token_kind, line_number, token_length, last_of_run,
                    input ready);
    modport sink   (input valid, token_kind, line_number, token_length, last_of_run,
                    output ready);
endinterface

### hw/rtl/slts_kw_match.sv
`timescale 1ns / 1ps
// Keyword matcher: compares the stored word against all keywords in parallel.
module slts_kw_match (
    input  slts_pkg::word_store_t                 word_store,
    input  logic [slts_pkg::WLEN_W-1:0]           word_length,
    output logic [slts_pkg::KIND_W-1:0]           word_kind
);

    always_comb
    begin
        logic hit;
        int   pos;
        word_kind = slts_pkg::K_ID;
        for (int k = slts_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            hit = (32'(word_length) == slts_pkg::KW_LEN[k]);
            for (int i = 0; i < slts_pkg::KEYWORD_CHARS; i++)
            begin
                pos = slts_pkg::KW_LEN[k] - 1 - i;
                if (pos >= 0)
                begin
                    if (slts_pkg::KW_TEXT[k][pos*8 +: 8] != {1'b0, word_store[i]})
                        hit = 1'b0;
                end
            end
            if (hit)
                word_kind = slts_pkg::KW_CODE[k];
        end
    end

endmodule

### hw/rtl/slts_res_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per transaction.
module slts_res_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slts_pkg::res_push_t  push,
    output logic                 room,
    slts_out_if.source           out_ch
);

    slts_pkg::result_t               mem_reg [slts_pkg::RES_FIFO_DEPTH];
    logic [slts_pkg::RES_PTR_W-1:0]  wr_reg, wr_next;
    logic [slts_pkg::RES_PTR_W-1:0]  rd_reg, rd_next;
    logic [slts_pkg::RES_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            pop;
    logic [slts_pkg::RES_PTR_W-1:0]  wr_plus1;

    assign pop      = out_ch.valid && out_ch.ready;
    assign room     = (32'(cnt_reg) <= slts_pkg::RES_FIFO_DEPTH - 2);
    assign wr_plus1 = wr_reg + 1'b1;

    assign out_ch.valid        = (cnt_reg != '0);
    assign out_ch.token_kind   = mem_reg[rd_reg].kind;
    assign out_ch.line_number  = mem_reg[rd_reg].line;
    assign out_ch.token_length = mem_reg[rd_reg].len;
    assign out_ch.last_of_run  = mem_reg[rd_reg].last;

    always_comb
    begin
        wr_next  = wr_reg + slts_pkg::RES_PTR_W'(push.en0) + slts_pkg::RES_PTR_W'(push.en1);
        rd_next  = rd_reg + slts_pkg::RES_PTR_W'(pop);
        cnt_next = cnt_reg + slts_pkg::RES_CNT_W'(push.en0) + slts_pkg::RES_CNT_W'(push.en1)
                   - slts_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.en0)
            mem_reg[wr_reg] <= push.d0;
        if (push.en1)
            mem_reg[wr_plus1] <= push.d1;
    end

endmodule

### hw/rtl/small_language_token_scanner.sv
`timescale 1ns / 1ps
// Top level: character-at-a-time token scanner for a small block-structured language.
//
// The scanner takes one character transaction per clock and updates its scan
// state in the same cycle, so a new character is accepted every cycle as long
// as the result queue has room. Each character produces zero, one or two token
// transactions (two when a character ends a pending token and then forms a
// token of its own); these go into a four-entry result queue that drives the
// output channel directly; a token is registered into the queue as its
// character is accepted. Input ready is high while at least two queue entries
// are free. The output side moves one token per cycle while the sink is ready,
// so two-token characters and sink stalls can slow input below one per cycle.
// Keywords are recognized case-insensitively by a parallel compare over an
// eight-character word store; longer words are always ID. end_of_text flushes
// any pending token and then emits SCANEOF; the line count survives it.
// There is no setup pass after reset.
module small_language_token_scanner (
    input  logic        clk,
    input  logic        rst_n,
    slts_in_if.sink     in_ch,
    slts_out_if.source  out_ch
);

    // Scan state
    slts_pkg::mode_t                    mode_reg, mode_next;
    logic [slts_pkg::WLEN_W-1:0]        wlen_reg, wlen_next;
    logic [slts_pkg::LINE_W-1:0]        line_reg, line_next;
    slts_pkg::word_store_t              word_store_reg;

    // Word store write port
    logic                               st_we;
    logic [slts_pkg::KC_IDX_W-1:0]      st_idx;

    logic                               accept;
    logic                               room;
    logic [7:0]                         c;
    logic                               eot;
    logic                               is_letter, is_digit, is_alnum;
    logic [6:0]                         up_char;
    logic                               reproc;
    logic [slts_pkg::KIND_W-1:0]        word_kind;
    logic [slts_pkg::WLEN_W-1:0]        wlen_grow;

    // Emissions: pending token (a) and token from the character itself (b)
    logic                               ea_v, eb_v;
    logic [slts_pkg::KIND_W-1:0]        ea_kind, eb_kind;
    logic [slts_pkg::LEN_W-1:0]         ea_len;
    slts_pkg::res_push_t                push;

    assign c         = in_ch.char_code;
    assign eot       = in_ch.end_of_text;
    assign accept    = in_ch.valid && in_ch.ready;
    assign in_ch.ready = room;

    assign is_letter = (c > 8'd64 && c < 8'd91) || (c > 8'd96 && c < 8'd123);
    assign is_digit  = (c > 8'd47 && c < 8'd58);
    assign is_alnum  = is_letter || is_digit;
    // fold lower case onto upper case
    assign up_char   = (c > 8'd96) ? 7'(c - 8'd32) : c[6:0];

    assign wlen_grow = (32'(wlen_reg) < slts_pkg::MAX_TOKEN_LENGTH)
                       ? wlen_reg + 1'b1 : wlen_reg;

    slts_kw_match u_kw_match (
        .word_store  (word_store_reg),
        .word_length (wlen_reg),
        .word_kind   (word_kind)
    );

    // Does the character, after closing the pending token, start over from idle?
    always_comb
    begin
        case (mode_reg)
            slts_pkg::MODE_IDLE:    reproc = 1'b1;
            slts_pkg::MODE_WORD:    reproc = !is_alnum;
            slts_pkg::MODE_MINUS:   reproc = !(c == slts_pkg::CH_MINUS || is_digit);
            slts_pkg::MODE_NEGNUM:  reproc = !is_digit;
            slts_pkg::MODE_COMMENT: reproc = (c == slts_pkg::CH_NL);
            slts_pkg::MODE_COLON:   reproc = (c != slts_pkg::CH_EQ);
            slts_pkg::MODE_LESS:    reproc = !(c == slts_pkg::CH_SPACE || c == slts_pkg::CH_EQ ||
                                               c == slts_pkg::CH_GT);
            slts_pkg::MODE_GREATER: reproc = !(c == slts_pkg::CH_SPACE || c == slts_pkg::CH_EQ);
            default:                reproc = 1'b1;
        endcase
    end

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        wlen_next = wlen_reg;
        line_next = line_reg;
        st_we     = 1'b0;
        st_idx    = '0;
        if (eot)
        begin
            mode_next = slts_pkg::MODE_IDLE;
            wlen_next = '0;
        end
        else if (!reproc)
        begin
            case (mode_reg)
                slts_pkg::MODE_WORD:
                begin
                    st_we     = (32'(wlen_reg) < slts_pkg::KEYWORD_CHARS);
                    st_idx    = wlen_reg[slts_pkg::KC_IDX_W-1:0];
                    wlen_next = wlen_grow;
                end
                slts_pkg::MODE_MINUS:
                begin
                    if (c == slts_pkg::CH_MINUS)
                        mode_next = slts_pkg::MODE_COMMENT;
                    else
                    begin
                        mode_next = slts_pkg::MODE_NEGNUM;
                        wlen_next = slts_pkg::WLEN_W'(2);
                    end
                end
                slts_pkg::MODE_NEGNUM:  wlen_next = wlen_grow;
                slts_pkg::MODE_COMMENT: mode_next = slts_pkg::MODE_COMMENT;
                default:                mode_next = slts_pkg::MODE_IDLE;
            endcase
        end
        else
        begin
            // character scanned from idle
            mode_next = slts_pkg::MODE_IDLE;
            wlen_next = '0;
            if (is_letter)
            begin
                st_we     = 1'b1;
                mode_next = slts_pkg::MODE_WORD;
                wlen_next = slts_pkg::WLEN_W'(1);
            end
            else
            begin
                case (c)
                    slts_pkg::CH_NL:
                        if (line_reg != {slts_pkg::LINE_W{1'b1}})
                            line_next = line_reg + 1'b1;
                    slts_pkg::CH_MINUS: mode_next = slts_pkg::MODE_MINUS;
                    slts_pkg::CH_COLON: mode_next = slts_pkg::MODE_COLON;
                    slts_pkg::CH_LT:    mode_next = slts_pkg::MODE_LESS;
                    slts_pkg::CH_GT:    mode_next = slts_pkg::MODE_GREATER;
                    default:            mode_next = slts_pkg::MODE_IDLE;
                endcase
            end
        end
    end

    // Token emission
    always_comb
    begin
        ea_v    = 1'b0;
        ea_kind = slts_pkg::K_ERROR;
        ea_len  = 8'd1;
        eb_v    = 1'b0;
        eb_kind = slts_pkg::K_ERROR;
        if (eot)
        begin
            case (mode_reg)
                slts_pkg::MODE_WORD:
                begin
                    ea_v    = 1'b1;
                    ea_kind = word_kind;
                    ea_len  = slts_pkg::sat_len(wlen_reg);
                end
                slts_pkg::MODE_MINUS:
                begin
                    ea_v    = 1'b1;
                    ea_kind = slts_pkg::K_MINUSOP;
                end
                slts_pkg::MODE_NEGNUM:
                begin
                    ea_v    = 1'b1;
                    ea_kind = slts_pkg::K_INTLITERAL;
                    ea_len  = slts_pkg::sat_len(wlen_reg);
                end
                slts_pkg::MODE_COLON, slts_pkg::MODE_LESS, slts_pkg::MODE_GREATER:
                    ea_v = 1'b1;
                default: ea_v = 1'b0;
            endcase
            eb_v    = 1'b1;
            eb_kind = slts_pkg::K_SCANEOF;
        end
        else
        begin
            case (mode_reg)
                slts_pkg::MODE_WORD:
                begin
                    ea_v    = reproc;
                    ea_kind = word_kind;
                    ea_len  = slts_pkg::sat_len(wlen_reg);
                end
                slts_pkg::MODE_MINUS:
                begin
                    ea_v    = reproc;
                    ea_kind = slts_pkg::K_MINUSOP;
                end
                slts_pkg::MODE_NEGNUM:
                begin
                    ea_v    = reproc;
                    ea_kind = slts_pkg::K_INTLITERAL;
                    ea_len  = slts_pkg::sat_len(wlen_reg);
                end
                slts_pkg::MODE_COLON:
                begin
                    ea_v = 1'b1;
                    if (c == slts_pkg::CH_EQ)
                    begin
                        ea_kind = slts_pkg::K_ASSIGNOP;
                        ea_len  = 8'd2;
                    end
                end
                slts_pkg::MODE_LESS:
                begin
                    ea_v = 1'b1;
                    if (c == slts_pkg::CH_SPACE)
                        ea_kind = slts_pkg::K_LESSOP;
                    else if (c == slts_pkg::CH_EQ)
                    begin
                        ea_kind = slts_pkg::K_LESSEQUALOP;
                        ea_len  = 8'd2;
                    end
                    else if (c == slts_pkg::CH_GT)
                    begin
                        ea_kind = slts_pkg::K_NOTEQUALOP;
                        ea_len  = 8'd2;
                    end
                end
                slts_pkg::MODE_GREATER:
                begin
                    ea_v = 1'b1;
                    if (c == slts_pkg::CH_SPACE)
                        ea_kind = slts_pkg::K_GREATEROP;
                    else if (c == slts_pkg::CH_EQ)
                    begin
                        ea_kind = slts_pkg::K_GREATEREQUALOP;
                        ea_len  = 8'd2;
                    end
                end
                default: ea_v = 1'b0;
            endcase
            if (reproc && !is_letter)
            begin
                eb_v = 1'b1;
                case (c)
                    slts_pkg::CH_SPACE, slts_pkg::CH_TAB, slts_pkg::CH_NL,
                    slts_pkg::CH_MINUS, slts_pkg::CH_COLON, slts_pkg::CH_LT,
                    slts_pkg::CH_GT:    eb_v    = 1'b0;
                    slts_pkg::CH_LPAREN: eb_kind = slts_pkg::K_LPAREN;
                    slts_pkg::CH_RPAREN: eb_kind = slts_pkg::K_RPAREN;
                    slts_pkg::CH_SEMI:   eb_kind = slts_pkg::K_SEMICOLON;
                    slts_pkg::CH_COMMA:  eb_kind = slts_pkg::K_COMMA;
                    slts_pkg::CH_PLUS:   eb_kind = slts_pkg::K_PLUSOP;
                    slts_pkg::CH_STAR:   eb_kind = slts_pkg::K_MULTOP;
                    slts_pkg::CH_SLASH:  eb_kind = slts_pkg::K_DIVOP;
                    slts_pkg::CH_BANG:   eb_kind = slts_pkg::K_NOTOP;
                    slts_pkg::CH_EQ:     eb_kind = slts_pkg::K_EQUALOP;
                    default:             eb_kind = slts_pkg::K_ERROR;
                endcase
            end
        end
    end

    // Pack into queue slots; every token carries the line before any newline count
    always_comb
    begin
        push.en0       = accept && (ea_v || eb_v);
        push.en1       = accept && ea_v && eb_v;
        push.d0.kind   = ea_v ? ea_kind : eb_kind;
        push.d0.line   = line_reg;
        push.d0.len    = ea_v ? ea_len : 8'd1;
        push.d0.last   = !(ea_v && eb_v);
        push.d1.kind   = eb_kind;
        push.d1.line   = line_reg;
        push.d1.len    = 8'd1;
        push.d1.last   = 1'b1;
    end

    slts_res_fifo u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= slts_pkg::MODE_IDLE;
            wlen_reg <= '0;
            line_reg <= slts_pkg::LINE_W'(1);
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            wlen_reg <= wlen_next;
            line_reg <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !eot && st_we)
            word_store_reg[st_idx] <= up_char;
    end

endmodule

### tb/small_language_token_scanner_tb.sv
`timescale 1ns / 1ps
// Testbench for the token scanner: random and directed character streams against a token predictor.
module small_language_token_scanner_tb;
    import slts_pkg::*;

    localparam int RANDOM_ITEMS    = 1950;
    localparam int LONG_HOLD       = 300;   // one long sink hold-off, fills the result queue
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES    = 64;    // settle time after the last expected token
    localparam int LONG_LEXEME     = 257;   // long enough to saturate the length field

    // ------------------------------------------------------------------------
    // Token predictor and store of expected tokens.
    // note_char advances the scan state by one accepted character transaction and
    // queues the tokens it produces; check_token pops the oldest one and compares.
    // ------------------------------------------------------------------------
    class token_scoreboard;
        result_t    pending[$];
        result_t    step_tokens[$];
        int         mismatches;
        mode_t      mode;
        logic [6:0] word_chars [KEYWORD_CHARS];
        int         word_len;
        int         line_no;

        function new();
            mismatches = 0;
            mode       = MODE_IDLE;
            word_len   = 0;
            line_no    = 1;
            foreach (word_chars[i])
                word_chars[i] = '0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        // upper-case fold, kept at 7 bits like the word store
        function logic [6:0] fold(logic [7:0] c);
            logic [7:0] u;
            u = (c >= "a") ? c - 8'd32 : c;
            return u[6:0];
        endfunction

        function void grow();
            if (word_len < MAX_TOKEN_LENGTH)
                word_len++;
        endfunction

        function void push_token(logic [KIND_W-1:0] kind, int len);
            result_t r;
            r.kind = kind;
            r.line = line_no[LINE_W-1:0];
            r.len  = (len > 255) ? 8'hFF : len[LEN_W-1:0];
            r.last = 1'b0;
            step_tokens.push_back(r);
        endfunction

        // keyword lookup; anything longer than the store is an identifier
        function logic [KIND_W-1:0] word_kind();
            logic [8*KEYWORD_CHARS-1:0] text;
            int i;
            if (word_len > KEYWORD_CHARS)
                return K_ID;
            text = '0;
            for (i = 0; i < word_len; i++)
                text = {text[8*KEYWORD_CHARS-9:0], 1'b0, word_chars[i]};
            case (text)
                "BEGIN":    return K_BEGIN;
                "END":      return K_END;
                "READ":     return K_READ;
                "WRITE":    return K_WRITE;
                "IF":       return K_IF;
                "THEN":     return K_THEN;
                "ELSE":     return K_ELSE;
                "ENDIF":    return K_ENDIF;
                "WHILE":    return K_WHILE;
                "ENDWHILE": return K_ENDWHILE;
                "FALSEOP":  return K_FALSEOP;
                "TRUEOP":   return K_TRUEOP;
                "NULLOP":   return K_NULLOP;
                default:    return K_ID;
            endcase
        endfunction

        // character seen between tokens
        function void start_token(logic [7:0] c);
            word_len = 0;
            if (is_alpha(c))
            begin
                word_chars[0] = fold(c);
                word_len      = 1;
                mode          = MODE_WORD;
                return;
            end
            case (c)
                CH_SPACE, CH_TAB: ;
                CH_NL:     if (line_no < 65535) line_no++;
                CH_MINUS:  mode = MODE_MINUS;
                CH_COLON:  mode = MODE_COLON;
                CH_LT:     mode = MODE_LESS;
                CH_GT:     mode = MODE_GREATER;
                CH_LPAREN: push_token(K_LPAREN, 1);
                CH_RPAREN: push_token(K_RPAREN, 1);
                CH_SEMI:   push_token(K_SEMICOLON, 1);
                CH_COMMA:  push_token(K_COMMA, 1);
                CH_PLUS:   push_token(K_PLUSOP, 1);
                CH_STAR:   push_token(K_MULTOP, 1);
                CH_SLASH:  push_token(K_DIVOP, 1);
                CH_BANG:   push_token(K_NOTOP, 1);
                CH_EQ:     push_token(K_EQUALOP, 1);
                default:   push_token(K_ERROR, 1);
            endcase
        endfunction

        // a character that ends a pending token falls through and is rescanned from idle
        function void scan(logic [7:0] c);
            mode_t m;
            m    = mode;
            mode = MODE_IDLE;
            case (m)
                MODE_WORD:
                begin
                    if (is_alpha(c) || is_num(c))
                    begin
                        if (word_len < KEYWORD_CHARS)
                            word_chars[word_len] = fold(c);
                        grow();
                        mode = MODE_WORD;
                        return;
                    end
                    push_token(word_kind(), word_len);
                end
                MODE_MINUS:
                begin
                    if (c == CH_MINUS)
                    begin
                        mode = MODE_COMMENT;
                        return;
                    end
                    if (is_num(c))
                    begin
                        word_len = 2;
                        mode     = MODE_NEGNUM;
                        return;
                    end
                    push_token(K_MINUSOP, 1);
                end
                MODE_NEGNUM:
                begin
                    if (is_num(c))
                    begin
                        grow();
                        mode = MODE_NEGNUM;
                        return;
                    end
                    push_token(K_INTLITERAL, word_len);
                end
                MODE_COMMENT:
                begin
                    if (c != CH_NL)
                    begin
                        mode = MODE_COMMENT;
                        return;
                    end
                end
                MODE_COLON:
                begin
                    if (c == CH_EQ)
                    begin
                        push_token(K_ASSIGNOP, 2);
                        return;
                    end
                    push_token(K_ERROR, 1);
                end
                MODE_LESS:
                begin
                    if (c == CH_SPACE)
                    begin
                        push_token(K_LESSOP, 1);
                        return;
                    end
                    if (c == CH_EQ)
                    begin
                        push_token(K_LESSEQUALOP, 2);
                        return;
                    end
                    if (c == CH_GT)
                    begin
                        push_token(K_NOTEQUALOP, 2);
                        return;
                    end
                    push_token(K_ERROR, 1);
                end
                MODE_GREATER:
                begin
                    if (c == CH_SPACE)
                    begin
                        push_token(K_GREATEROP, 1);
                        return;
                    end
                    if (c == CH_EQ)
                    begin
                        push_token(K_GREATEREQUALOP, 2);
                        return;
                    end
                    push_token(K_ERROR, 1);
                end
                default: ;
            endcase
            start_token(c);
        endfunction

        // end of text: flush, then SCANEOF; the line count survives
        function void flush_text();
            case (mode)
                MODE_WORD:   push_token(word_kind(), word_len);
                MODE_MINUS:  push_token(K_MINUSOP, 1);
                MODE_NEGNUM: push_token(K_INTLITERAL, word_len);
                MODE_COLON, MODE_LESS, MODE_GREATER: push_token(K_ERROR, 1);
                default: ;
            endcase
            push_token(K_SCANEOF, 1);
            mode     = MODE_IDLE;
            word_len = 0;
        endfunction

        function void note_char(logic [7:0] c, logic eot);
            result_t r;
            int i;
            step_tokens.delete();
            if (eot)
                flush_text();
            else
                scan(c);
            for (i = 0; i < step_tokens.size(); i++)
            begin
                r      = step_tokens[i];
                r.last = (i == step_tokens.size() - 1);
                pending.push_back(r);
            end
        endfunction

        function void check_token(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected token kind=%0d line=%0d len=%0d last=%0b",
                             $realtime, got.kind, got.line, got.len, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.line !== want.line ||
                got.len !== want.len || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: token mismatch: expected kind=%0d line=%0d len=%0d last=%0b,",
                             $realtime, want.kind, want.line, want.len, want.last,
                             " got kind=%0d line=%0d len=%0d last=%0b",
                             got.kind, got.line, got.len, got.last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    slts_in_if  in_ch ();
    slts_out_if out_ch ();

    small_language_token_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    token_scoreboard tracker;
    int      sent_count    = 0;     // accepted character transactions sent by the driver
    bit      src_steady    = 1'b0;  // sender offers back to back while set
    bit      hold_off_req  = 1'b0;  // asks the sink for one long hold-off
    int      quiet_cycles  = 0;
    result_t seen_token;

    string      kw_pool [13] = '{"BEGIN", "END", "READ", "WRITE", "IF", "THEN", "ELSE",
                                 "ENDIF", "WHILE", "ENDWHILE", "FALSEOP", "TRUEOP", "NULLOP"};
    logic [7:0] op_chars [9] = '{CH_LPAREN, CH_RPAREN, CH_STAR, CH_SEMI, CH_COMMA,
                                 CH_PLUS, CH_SLASH, CH_BANG, CH_EQ};

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: notes accepted characters, checks accepted tokens, runs the watchdog.
    // Everything is sampled at the rising edge; inputs only move at the falling edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_char(in_ch.char_code, in_ch.end_of_text);
            if (out_ch.valid && out_ch.ready)
            begin
                seen_token.kind = out_ch.token_kind;
                seen_token.line = out_ch.line_number;
                seen_token.len  = out_ch.token_length;
                seen_token.last = out_ch.last_of_run;
                tracker.check_token(seen_token);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // Sink side: random stalls, phases of steady readiness, and one long hold-off
    // counted here while the sender keeps offering, so the result queue fills and
    // input ready drops.
    // ------------------------------------------------------------------------
    initial
    begin : sink_side
        int stall;
        int cyc;
        bit steady;
        stall        = 0;
        cyc          = 0;
        steady       = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 128 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall        = LONG_HOLD;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall = pick_gap(steady);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: one character transaction, returns at the edge where it is accepted.
    // valid stays high across back-to-back transactions; it is only lowered for a gap.
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = pick_gap(src_steady);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.char_code   <= c;
        in_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    // word or literal long enough to saturate the counters
    task automatic send_long(input bit literal);
        int i;
        send_char(literal ? CH_MINUS : rand_letter(), 1'b0);
        for (i = 1; i < LONG_LEXEME; i++)
            send_char(literal ? rand_digit() : rand_alnum(), 1'b0);
        send_char(CH_SPACE, 1'b0);
    endtask

    task automatic send_separator();
        case ($urandom_range(0, 5))
            0, 1, 2: send_char(CH_SPACE, 1'b0);
            3:       send_char(CH_NL, 1'b0);
            4:       send_char(CH_SEMI, 1'b0);
            default: send_char(CH_LPAREN, 1'b0);
        endcase
    endtask

    // One random lexeme: mostly well-formed tokens with random content, some noise.
    task automatic send_lexeme();
        int pick;
        int n;
        int i;
        logic [7:0] c;
        string kw;
        pick = $urandom_range(0, 99);
        if (pick < 14)
        begin
            // keyword in mixed case
            kw = kw_pool[$urandom_range(0, 12)];
            for (i = 0; i < kw.len(); i++)
            begin
                c = kw[i];
                if ($urandom_range(0, 1))
                    c = c + 8'd32;
                send_char(c, 1'b0);
            end
            if ($urandom_range(0, 3) != 0)
                send_separator();
        end
        else if (pick < 26)
        begin
            // identifier, sometimes past the keyword store
            n = $urandom_range(1, 12);
            send_char(rand_letter(), 1'b0);
            for (i = 1; i < n; i++)
                send_char(rand_alnum(), 1'b0);
            if ($urandom_range(0, 3) != 0)
                send_separator();
        end
        else if (pick < 34)
        begin
            // negative literal
            send_char(CH_MINUS, 1'b0);
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                send_char(rand_digit(), 1'b0);
        end
        else if (pick < 38)
            send_char(CH_MINUS, 1'b0);
        else if (pick < 43)
        begin
            // comment: any bytes but newline, then newline
            send_char(CH_MINUS, 1'b0);
            send_char(CH_MINUS, 1'b0);
            n = $urandom_range(0, 10);
            for (i = 0; i < n; i++)
            begin
                c = rand_byte();
                send_char((c == CH_NL) ? CH_SPACE : c, 1'b0);
            end
            send_char(CH_NL, 1'b0);
        end
        else if (pick < 58)
            send_char(op_chars[$urandom_range(0, 8)], 1'b0);
        else if (pick < 63)
        begin
            send_char(CH_COLON, 1'b0);
            send_char(($urandom_range(0, 3) != 0) ? CH_EQ : rand_byte(), 1'b0);
        end
        else if (pick < 70)
        begin
            send_char(CH_LT, 1'b0);
            case ($urandom_range(0, 3))
                0:       send_char(CH_SPACE, 1'b0);
                1:       send_char(CH_EQ, 1'b0);
                2:       send_char(CH_GT, 1'b0);
                default: send_char(rand_byte(), 1'b0);
            endcase
        end
        else if (pick < 76)
        begin
            send_char(CH_GT, 1'b0);
            case ($urandom_range(0, 2))
                0:       send_char(CH_SPACE, 1'b0);
                1:       send_char(CH_EQ, 1'b0);
                default: send_char(rand_byte(), 1'b0);
            endcase
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 2))
                0:       send_char(CH_SPACE, 1'b0);
                1:       send_char(CH_TAB, 1'b0);
                default: send_char(CH_NL, 1'b0);
            endcase
        end
        else if (pick < 98)
            send_char(rand_byte(), 1'b0);
        else
            send_char(rand_byte(), 1'b1);  // end of text, char ignored
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int target;
        bit word_done;
        bit literal_done;
        tracker           = new();
        word_done         = 1'b0;
        literal_done      = 1'b0;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.char_code   = 8'h00;
        in_ch.end_of_text = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: keyword, '<>', negative literal, ':=', identifier ended by an
        // operator, '>=', bare '<' before a letter (error, then rescanned), comment
        // ended by newline, tab, both extreme codes, NOTOP, then end of text.
        send_text("if<>-7:=A1>= <q--\n\t");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_BANG, 1'b0);
        send_char(8'hA5, 1'b1);

        // Random part; first the long sink hold-off while characters keep coming.
        hold_off_req = 1'b1;
        target       = sent_count + RANDOM_ITEMS;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 15) == 0)
                src_steady = ($urandom_range(0, 2) == 0);
            if (!word_done && sent_count > target - 1300)
            begin
                word_done = 1'b1;
                send_long(1'b0);
            end
            else if (!literal_done && sent_count > target - 800)
            begin
                literal_done = 1'b1;
                send_long(1'b1);
            end
            else
                send_lexeme();
        end
        send_char(rand_byte(), 1'b1);
        @(negedge clk);
        in_ch.valid <= 1'b0;

        // wait out the tokens still owed; the watchdog catches a hang
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
